FILE: hw/rtl/oetc_pkg.sv
package oetc_pkg;

	localparam int CHAR_W = 8;
	localparam int LINE_W = 4;
	localparam int ADDR_W = 10;
	localparam int WORD_W = 16;

	// attribute word layout
	localparam int FG_LSB = 8;
	localparam int BG_LSB = 12;
	localparam logic [WORD_W-1:0] ATTR_TILE_DIS  = 16'h8000;
	localparam logic [WORD_W-1:0] ATTR_BG_FIELD  = 16'h7000;
	localparam logic [WORD_W-1:0] ATTR_ALPHA_DIS = 16'h0800;
	localparam logic [WORD_W-1:0] ATTR_FG_FIELD  = 16'h0700;
	localparam logic [WORD_W-1:0] ATTR_INVERT    = 16'h0080;

	// message bytes with a meaning of their own
	localparam logic [CHAR_W-1:0] CH_END     = 8'h00;
	localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [CHAR_W-1:0] CH_TILE    = 8'h74; // t
	localparam logic [CHAR_W-1:0] CH_UNTILE  = 8'h65; // e
	localparam logic [CHAR_W-1:0] CH_ALPHA   = 8'h68; // h
	localparam logic [CHAR_W-1:0] CH_UNALPHA = 8'h61; // a
	localparam logic [CHAR_W-1:0] CH_INV     = 8'h77; // w
	localparam logic [CHAR_W-1:0] CH_UNINV   = 8'h72; // r
	localparam logic [CHAR_W-1:0] CH_FG      = 8'h66; // f
	localparam logic [CHAR_W-1:0] CH_BG      = 8'h62; // b
	localparam logic [CHAR_W-1:0] CH_DIGIT0  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIGIT7  = 8'h37;

	typedef enum logic [4:0] {
		MODE_NORMAL  = 5'b00001,
		MODE_PERCENT = 5'b00010,
		MODE_FG      = 5'b00100,
		MODE_BG      = 5'b01000,
		MODE_DONE    = 5'b10000
	} mode_t;

endpackage

FILE: hw/rtl/oetc_if.sv
interface oetc_in_if;
	import oetc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic [LINE_W-1:0] line_index;
	logic              first_of_message;

	modport source (output valid, char_code, line_index, first_of_message, input ready);
	modport sink (input valid, char_code, line_index, first_of_message, output ready);
endinterface

interface oetc_out_if;
	import oetc_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] cell_address;
	logic [WORD_W-1:0] cell_word;

	modport source (output valid, cell_address, cell_word, input ready);
	modport sink (input valid, cell_address, cell_word, output ready);
endinterface

FILE: hw/rtl/osd_escape_text_to_cells.sv
// Escape-text decoder for one on-screen-display line: message bytes come in on
// "text", one item per byte, and each printable byte leaves as one character-RAM
// write on "cells" (address line*CELLS_PER_LINE+column mod 1024, word byte plus
// attributes mod 65536) until the line is full; '%' escapes change the attribute
// word or print a literal '%'. The block takes one byte every cycle while "cells"
// does not stall; a byte is held in the input register and its cell write then
// appears from the result register. While a cell write waits on "cells" the result
// register holds, and a byte in the input register holds behind it and stalls "text".
module osd_escape_text_to_cells
	import oetc_pkg::*;
#(
	parameter int CELLS_PER_LINE = 64,  // 8 .. 256
	parameter int NUM_LINES      = 16   // 1 .. 64
) (
	input  logic           clk,
	input  logic           arst_n,
	oetc_in_if.sink        text,
	oetc_out_if.source     cells
);

	// column counts up to and including a full line
	localparam int COL_W = $clog2(CELLS_PER_LINE + 1);
	localparam logic [COL_W-1:0] COL_FULL = COL_W'(CELLS_PER_LINE);

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [LINE_W-1:0] line_s1;
	logic              first_s1;

	// message state
	mode_t             mode_q;
	logic [WORD_W-1:0] attr_q;
	logic [COL_W-1:0]  col_q;
	logic [LINE_W-1:0] line_q;

	// result register
	logic              out_valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [WORD_W-1:0] word_q;

	logic advance;
	logic step;

	// line_index mod NUM_LINES as a constant lookup
	logic [LINE_W-1:0] line_mod [2**LINE_W];
	for (genvar i = 0; i < 2**LINE_W; i++) begin : g_line_mod
		assign line_mod[i] = LINE_W'(i % NUM_LINES);
	end

	// result register frees up when empty or being drained
	assign advance    = !out_valid_q || cells.ready;
	assign step       = valid_s1 && advance;
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			char_s1  <= text.char_code;
			line_s1  <= text.line_index;
			first_s1 <= text.first_of_message;
		end
	end

	// state as seen by this byte: a new message starts from a clean slate
	mode_t             mode_e;
	logic [WORD_W-1:0] attr_e;
	logic [COL_W-1:0]  col_e;
	logic [LINE_W-1:0] line_e;

	// next state and result
	mode_t             mode_d;
	logic [WORD_W-1:0] attr_d;
	logic [COL_W-1:0]  col_d;
	logic              print;
	logic              emit;
	logic [ADDR_W-1:0] addr_d;
	logic [WORD_W-1:0] word_d;

	always_comb begin
		if (first_s1) begin
			mode_e = MODE_NORMAL;
			attr_e = '0;
			col_e  = '0;
			line_e = line_mod[line_s1];
		end else begin
			mode_e = mode_q;
			attr_e = attr_q;
			col_e  = col_q;
			line_e = line_q;
		end

		mode_d = mode_e;
		attr_d = attr_e;
		print  = 1'b0;

		case (mode_e)
			MODE_NORMAL: begin
				if (char_s1 == CH_END) begin
					mode_d = MODE_DONE;
				end else if (char_s1 == CH_PERCENT) begin
					mode_d = MODE_PERCENT;
				end else begin
					print = 1'b1;
				end
			end
			MODE_PERCENT: begin
				mode_d = MODE_NORMAL;
				case (char_s1)
					CH_END:     mode_d = MODE_DONE;
					CH_PERCENT: print  = 1'b1;
					CH_TILE:    attr_d = attr_e | ATTR_TILE_DIS;
					CH_UNTILE:  attr_d = attr_e & ~ATTR_TILE_DIS;
					CH_ALPHA:   attr_d = attr_e | ATTR_ALPHA_DIS;
					CH_UNALPHA: attr_d = attr_e & ~ATTR_ALPHA_DIS;
					CH_INV:     attr_d = attr_e | ATTR_INVERT;
					CH_UNINV:   attr_d = attr_e & ~ATTR_INVERT;
					CH_FG:      mode_d = MODE_FG;
					CH_BG:      mode_d = MODE_BG;
					default:    mode_d = MODE_NORMAL; // unknown escape dropped
				endcase
			end
			MODE_FG, MODE_BG: begin
				mode_d = MODE_NORMAL;
				if (char_s1 == CH_END) begin
					mode_d = MODE_DONE;
				end else if (char_s1 inside {[CH_DIGIT0:CH_DIGIT7]}) begin
					// digit value is the low three bits
					if (mode_e == MODE_FG) begin
						attr_d = (attr_e & ~ATTR_FG_FIELD)
							| (WORD_W'(char_s1[2:0]) << FG_LSB);
					end else begin
						attr_d = (attr_e & ~ATTR_BG_FIELD)
							| (WORD_W'(char_s1[2:0]) << BG_LSB);
					end
				end
			end
			default: mode_d = MODE_DONE;
		endcase

		// full line ends the message instead of writing
		col_d = col_e;
		emit  = 1'b0;
		if (print) begin
			if (col_e >= COL_FULL) begin
				mode_d = MODE_DONE;
			end else begin
				emit   = 1'b1;
				col_d  = col_e + 1'b1;
				mode_d = MODE_NORMAL;
			end
		end

		addr_d = ADDR_W'(32'(line_e) * CELLS_PER_LINE + 32'(col_e));
		word_d = WORD_W'(char_s1) + attr_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DONE;
			attr_q <= '0;
			col_q  <= '0;
			line_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			attr_q <= attr_d;
			col_q  <= col_d;
			line_q <= line_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			addr_q <= addr_d;
			word_q <= word_d;
		end
	end

	assign cells.valid        = out_valid_q;
	assign cells.cell_address = addr_q;
	assign cells.cell_word    = word_q;

endmodule
